/* hw/rtl/assert_macros.svh */
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GLPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glpw assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GLPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glpw assertion failed");

`endif

/* hw/rtl/glpw_pkg.sv */
// ---------------------------------------------------------------------------
// glpw_pkg
// shared types and constants of the graphic lcd page writer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package glpw_pkg;

	localparam int unsigned PIXEL_W              = 8;
	localparam int unsigned ROWS_PER_PAGE        = 8;
	localparam int unsigned CONTROLLER_COLUMNS_DEF = 64;

	// largest number of controllers that a frame can span
	localparam logic [1:0] MAX_CONTROLLERS = 2'd3;
	localparam logic [3:0] MAX_PAGES       = 4'd8;

	// register reset values
	localparam logic [7:0] THRESHOLD_RST   = 8'd127;
	localparam logic [1:0] CONTROLLERS_RST = 2'd3;
	localparam logic [3:0] PAGES_RST       = 4'd8;

	// register indexes
	localparam logic [1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [1:0] REG_CONTROLLERS = 2'd1;
	localparam logic [1:0] REG_PAGES       = 2'd2;

	// display commands
	localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
	localparam logic [7:0] CMD_SET_COL  = 8'h40;

	// packed column waiting for the sequencer
	typedef struct packed {
		logic [ROWS_PER_PAGE-1:0] bits;
		logic                     frame_start;
	} item_t;

endpackage

/* hw/rtl/glpw_lane.sv */
// ---------------------------------------------------------------------------
// glpw_lane
// one threshold lane: a grey pixel lights its bit when above the threshold
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glpw_lane (
	input  logic [glpw_pkg::PIXEL_W-1:0] pixel,
	input  logic [glpw_pkg::PIXEL_W-1:0] threshold,
	output logic                         lit
);
	import glpw_pkg::*;

	assign lit = (pixel > threshold);

endmodule

/* hw/rtl/glpw_seq.sv */
// ---------------------------------------------------------------------------
// glpw_seq
// bus write sequencer: position counters and the command / data beats
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glpw_seq #(
	parameter int unsigned CONTROLLER_COLUMNS = glpw_pkg::CONTROLLER_COLUMNS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  glpw_pkg::item_t     item,
	output logic                item_ready,
	input  logic [1:0]          ctl_cfg,
	input  logic [3:0]          pages_cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          chip_select,
	output logic                register_select,
	output logic [7:0]          bus_byte,
	output logic                last,
	output logic                frame_end
);
	import glpw_pkg::*;

	localparam int unsigned    COL_W    = $clog2(CONTROLLER_COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(CONTROLLER_COLUMNS - 1);

	typedef enum logic [1:0] {
		BEAT_PAGE,
		BEAT_COL,
		BEAT_DATA
	} beat_t;

	beat_t            beat_q;
	beat_t            kind;
	logic [2:0]       page_q;
	logic [1:0]       ctl_q;
	logic [COL_W-1:0] col_q;

	logic [2:0]       page_e;
	logic [1:0]       ctl_e;
	logic [COL_W-1:0] col_e;
	logic [1:0]       nctl;
	logic [3:0]       npg;
	logic             emit;
	logic             fend;
	logic             col_wrap;
	logic             ctl_wrap;
	logic             page_wrap;

	// frame start clears the position before this transaction is handled
	assign page_e = item.frame_start ? '0 : page_q;
	assign ctl_e  = item.frame_start ? '0 : ctl_q;
	assign col_e  = item.frame_start ? '0 : col_q;

	always_comb begin
		if (ctl_cfg == 2'd0) begin
			nctl = 2'd1;
		end else if (ctl_cfg > MAX_CONTROLLERS) begin
			nctl = MAX_CONTROLLERS;
		end else begin
			nctl = ctl_cfg;
		end
		if (pages_cfg == 4'd0) begin
			npg = 4'd1;
		end else if (pages_cfg > MAX_PAGES) begin
			npg = MAX_PAGES;
		end else begin
			npg = pages_cfg;
		end
	end

	assign emit       = item_valid && (!out_valid || out_ready);
	// commands only at the first column of a segment
	assign kind       = (beat_q == BEAT_PAGE && col_e != '0) ? BEAT_DATA : beat_q;
	assign item_ready = emit && (kind == BEAT_DATA);

	assign fend = ({1'b0, page_e} == npg - 4'd1) && (ctl_e == nctl - 2'd1) &&
		(col_e == COL_LAST);

	assign col_wrap  = (col_e == COL_LAST);
	assign ctl_wrap  = ({1'b0, ctl_e} + 3'd1) >= {1'b0, nctl};
	assign page_wrap = ({1'b0, page_e} + 4'd1) >= npg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q          <= BEAT_PAGE;
			page_q          <= '0;
			ctl_q           <= '0;
			col_q           <= '0;
			out_valid       <= 1'b0;
			chip_select     <= '0;
			register_select <= 1'b0;
			bus_byte        <= '0;
			last            <= 1'b0;
			frame_end       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid   <= 1'b1;
				chip_select <= ctl_e;
				unique case (kind)
					BEAT_PAGE: begin
						register_select <= 1'b0;
						bus_byte        <= {CMD_SET_PAGE[7:3], page_e};
						last            <= 1'b0;
						frame_end       <= 1'b0;
						beat_q          <= BEAT_COL;
					end
					BEAT_COL: begin
						register_select <= 1'b0;
						bus_byte        <= CMD_SET_COL;
						last            <= 1'b0;
						frame_end       <= 1'b0;
						beat_q          <= BEAT_DATA;
					end
					BEAT_DATA: begin
						register_select <= 1'b1;
						bus_byte        <= item.bits;
						last            <= 1'b1;
						frame_end       <= fend;
						beat_q          <= BEAT_PAGE;
						// advance column, then controller, then page
						if (col_wrap) begin
							col_q <= '0;
							if (ctl_wrap) begin
								ctl_q  <= '0;
								page_q <= page_wrap ? 3'd0 : page_e + 3'd1;
							end else begin
								ctl_q  <= ctl_e + 2'd1;
								page_q <= page_e;
							end
						end else begin
							col_q  <= col_e + COL_W'(1);
							ctl_q  <= ctl_e;
							page_q <= page_e;
						end
					end
					default: begin
						beat_q <= BEAT_PAGE;
					end
				endcase
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/graphic_lcd_page_writer.sv */
// ---------------------------------------------------------------------------
// graphic_lcd_page_writer
// packs grey pixel columns into display bytes and sequences the bus writes
// ---------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    pixel_row0..7, frame_start
// out       source     out_valid / out_ready  chip_select, register_select,
//                                             bus_byte, last, frame_end
// cfg       sink       cfg_we                 cfg_index, cfg_data
//
// the output register issues one bus write per cycle while out_ready is high;
// a column at the start of a controller segment sends set page and set column
// before its data byte, any other column only its data byte.
// eight threshold lanes compare in the accept cycle; the packed byte waits
// in one input stage while the previous column is still being sent.
// arst_n clears counters and valids and loads the register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module graphic_lcd_page_writer #(
	parameter int unsigned CONTROLLER_COLUMNS = glpw_pkg::CONTROLLER_COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_row0,
	input  logic [7:0] pixel_row1,
	input  logic [7:0] pixel_row2,
	input  logic [7:0] pixel_row3,
	input  logic [7:0] pixel_row4,
	input  logic [7:0] pixel_row5,
	input  logic [7:0] pixel_row6,
	input  logic [7:0] pixel_row7,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] chip_select,
	output logic       register_select,
	output logic [7:0] bus_byte,
	output logic       last,
	output logic       frame_end,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import glpw_pkg::*;

	logic [PIXEL_W-1:0]       pix [ROWS_PER_PAGE];
	logic [ROWS_PER_PAGE-1:0] lit;

	logic [7:0] threshold_q;
	logic [1:0] controllers_q;
	logic [3:0] pages_q;

	logic  valid_s1;
	item_t item_s1;
	logic  item_ready;

	assign pix[0] = pixel_row0;
	assign pix[1] = pixel_row1;
	assign pix[2] = pixel_row2;
	assign pix[3] = pixel_row3;
	assign pix[4] = pixel_row4;
	assign pix[5] = pixel_row5;
	assign pix[6] = pixel_row6;
	assign pix[7] = pixel_row7;

	// top row lands in bit 0
	for (genvar g = 0; g < ROWS_PER_PAGE; g++) begin : g_lane
		glpw_lane u_lane (
			.pixel     (pix[g]),
			.threshold (threshold_q),
			.lit       (lit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RST;
			controllers_q <= CONTROLLERS_RST;
			pages_q       <= PAGES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:   threshold_q   <= cfg_data;
				REG_CONTROLLERS: controllers_q <= cfg_data[1:0];
				REG_PAGES:       pages_q       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (in_valid && in_ready) begin
			valid_s1            <= 1'b1;
			item_s1.bits        <= lit;
			item_s1.frame_start <= frame_start;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	glpw_seq #(
		.CONTROLLER_COLUMNS (CONTROLLER_COLUMNS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (valid_s1),
		.item            (item_s1),
		.item_ready      (item_ready),
		.ctl_cfg         (controllers_q),
		.pages_cfg       (pages_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.chip_select     (chip_select),
		.register_select (register_select),
		.bus_byte        (bus_byte),
		.last            (last),
		.frame_end       (frame_end)
	);

endmodule

/* hw/rtl/glpw_checker.sv */
// ---------------------------------------------------------------------------
// glpw_checker
// port level checks on the result stream of the page writer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glpw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       register_select,
	input logic [7:0] bus_byte,
	input logic       last,
	input logic       frame_end
);

	// a stalled result stays offered
	`GLPW_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// command beats of a column follow each other without a gap
	`GLPW_ASSERT_NXT(a_cmd_burst, clk, arst_n, out_valid && out_ready && !last, out_valid)

	// commands are never the closing beat of a transaction
	`GLPW_ASSERT_IMP(a_cmd_not_last, clk, arst_n, out_valid && !register_select,
		!last && !frame_end)

	// frame end only on a data byte
	`GLPW_ASSERT_IMP(a_fend_data, clk, arst_n, out_valid && frame_end,
		register_select && last)

	// only set page or set column reach the bus as commands
	`GLPW_ASSERT_IMP(a_cmd_code, clk, arst_n, out_valid && !register_select,
		bus_byte[7:3] == 5'b10111 || bus_byte == 8'h40)

endmodule

bind graphic_lcd_page_writer glpw_checker u_glpw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.register_select (register_select),
	.bus_byte        (bus_byte),
	.last            (last),
	.frame_end       (frame_end)
);
